[sv/rgb_to_hsv_pixel_defines.svh]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_defines: assertion macros
// Shared property shorthands for the pixel converter checks.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RGBHSV_ASSERT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RGBHSV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Widths, fixed-point constants and pipeline types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbhsv_pkg;

	// field widths
	localparam int CHAN_W = 8;
	localparam int HUE_W  = 15;

	// hue in 1/64 degree: one sixth of the circle and the full circle
	localparam int HUE_SIXTH     = 3840;
	localparam int HUE_FULL      = 23040;
	localparam int HUE_OFS_GREEN = 2 * HUE_SIXTH;
	localparam int HUE_OFS_BLUE  = 4 * HUE_SIXTH;
	localparam int CHAN_MAX      = 255;

	// divider geometry: hue quotient <= 3840, sat quotient <= 255
	localparam int HUE_Q_W        = 12;
	localparam int SAT_Q_W        = 8;
	localparam int HUE_ACC_W      = CHAN_W + HUE_Q_W;
	localparam int SAT_ACC_W      = CHAN_W + SAT_Q_W;
	localparam int BITS_PER_STAGE = 2;
	localparam int HUE_DIV_STAGES = HUE_Q_W / BITS_PER_STAGE;
	localparam int SAT_DIV_STAGES = SAT_Q_W / BITS_PER_STAGE;

	// signed working width of the hue sum before wrap
	localparam int HUE_SUM_W = 16;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// payload of one divider stage
	typedef struct packed {
		logic [HUE_ACC_W-1:0] hue_acc;
		logic [SAT_ACC_W-1:0] sat_acc;
		logic [CHAN_W-1:0]    delta;
		logic [CHAN_W-1:0]    hi;
		logic                 neg;
		sector_t              sector;
		logic                 grey;
	} div_stage_t;

endpackage

[sv/rgbhsv_if.sv]
// ----------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready channels for RGB pixel beats and HSV pixel beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// rgb pixel channel
interface rgbhsv_rgb_if;
	import rgbhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

// hsv pixel channel
interface rgbhsv_hsv_if;
	import rgbhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue_out;
	logic [CHAN_W-1:0] sat_out;
	logic [CHAN_W-1:0] val_out;

	modport source (output valid, output hue_out, output sat_out, output val_out,
		input ready);
	modport sink (input valid, input hue_out, input sat_out, input val_out,
		output ready);
endinterface

[sv/rgb_to_hsv_pixel.sv]
// Each rgb beat passes the stage 1, numerator, divider and output registers.
// Throughput: one pixel per cycle unless hsv.ready stalls; both dividers are
// unrolled restoring dividers retiring two quotient bits per pipeline stage.
// Each stage advances when its successor has room, so bubbles collapse.
// Reset (arst_n low) clears only the stage valid bits; no other state.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Pipelined 8-bit RGB to fixed-point HSV converter, stateless per pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_defines.svh"

module rgb_to_hsv_pixel (
	input  logic          clk,
	input  logic          arst_n,
	rgbhsv_rgb_if.sink    rgb,
	rgbhsv_hsv_if.source  hsv
);
	import rgbhsv_pkg::*;

	// one restoring division bit: {new remainder, quotient bit}
	function automatic logic [CHAN_W:0] div_bit(
		input logic [CHAN_W-1:0] rem,
		input logic              nb,
		input logic [CHAN_W-1:0] d
	);
		logic [CHAN_W:0] t;
		logic [CHAN_W:0] sub;
		t   = {rem, nb};
		sub = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {sub[CHAN_W-1:0], 1'b1};
		end else begin
			return {t[CHAN_W-1:0], 1'b0};
		end
	endfunction

	// ------------------------------------------------------------------
	// stage 1: max, min, sector and hue difference
	// ------------------------------------------------------------------
	logic [CHAN_W-1:0] hi_c, lo_c, rg_hi, rg_lo;
	logic [CHAN_W:0]   diff_c, diff_neg_c;
	sector_t           sector_c;

	logic              valid_s1, ready_s1;
	logic [CHAN_W-1:0] hi_s1, delta_s1, mag_s1;
	logic              neg_s1;
	sector_t           sector_s1;

	// channel extremes, red wins ties then green
	always_comb begin
		rg_hi = (rgb.red_in >= rgb.green_in) ? rgb.red_in : rgb.green_in;
		rg_lo = (rgb.red_in <= rgb.green_in) ? rgb.red_in : rgb.green_in;
		hi_c  = (rg_hi >= rgb.blue_in) ? rg_hi : rgb.blue_in;
		lo_c  = (rg_lo <= rgb.blue_in) ? rg_lo : rgb.blue_in;
		if (rgb.red_in >= rgb.green_in && rgb.red_in >= rgb.blue_in) begin
			sector_c = SECT_RED;
			diff_c   = {1'b0, rgb.green_in} - {1'b0, rgb.blue_in};
		end else if (rgb.green_in >= rgb.blue_in) begin
			sector_c = SECT_GREEN;
			diff_c   = {1'b0, rgb.blue_in} - {1'b0, rgb.red_in};
		end else begin
			sector_c = SECT_BLUE;
			diff_c   = {1'b0, rgb.red_in} - {1'b0, rgb.green_in};
		end
		diff_neg_c = '0 - diff_c;
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= rgb.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (ready_s1 && rgb.valid) begin
			hi_s1     <= hi_c;
			delta_s1  <= hi_c - lo_c;
			neg_s1    <= diff_c[CHAN_W];
			mag_s1    <= diff_c[CHAN_W] ? diff_neg_c[CHAN_W-1:0] : diff_c[CHAN_W-1:0];
			sector_s1 <= sector_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: numerators; stages 3..8: two quotient bits each
	// ------------------------------------------------------------------
	div_stage_t div_s     [0:HUE_DIV_STAGES];
	logic       valid_div [0:HUE_DIV_STAGES];
	logic       ready_div [0:HUE_DIV_STAGES];

	logic [HUE_ACC_W-1:0] hue_num_c;
	logic [SAT_ACC_W-1:0] sat_num_c;

	// 3840*|diff| and 255*delta by shift and subtract
	always_comb begin
		hue_num_c = ({{HUE_Q_W{1'b0}}, mag_s1} << 12) - ({{HUE_Q_W{1'b0}}, mag_s1} << 8);
		sat_num_c = ({{SAT_Q_W{1'b0}}, delta_s1} << 8) - {{SAT_Q_W{1'b0}}, delta_s1};
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_div[0] <= 1'b0;
		end else if (ready_div[0]) begin
			valid_div[0] <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (ready_div[0] && valid_s1) begin
			div_s[0].hue_acc <= hue_num_c;
			div_s[0].sat_acc <= sat_num_c;
			div_s[0].delta   <= delta_s1;
			div_s[0].hi      <= hi_s1;
			div_s[0].neg     <= neg_s1;
			div_s[0].sector  <= sector_s1;
			div_s[0].grey    <= (delta_s1 == '0);
		end
	end

	assign ready_s1 = !valid_s1 || ready_div[0];

	logic ready_s9;

	for (genvar k = 1; k <= HUE_DIV_STAGES; k++) begin : g_div
		div_stage_t nxt;

		// two restoring steps; saturation finishes in the first stages
		always_comb begin : step
			logic [CHAN_W:0] hst;
			logic [CHAN_W:0] sst;
			nxt = div_s[k-1];
			for (int i = 0; i < BITS_PER_STAGE; i++) begin
				hst = div_bit(nxt.hue_acc[HUE_ACC_W-1 -: CHAN_W],
					nxt.hue_acc[HUE_Q_W-1], nxt.delta);
				nxt.hue_acc = {hst[CHAN_W:1], nxt.hue_acc[HUE_Q_W-2:0], hst[0]};
				if (k <= SAT_DIV_STAGES) begin
					sst = div_bit(nxt.sat_acc[SAT_ACC_W-1 -: CHAN_W],
						nxt.sat_acc[SAT_Q_W-1], nxt.hi);
					nxt.sat_acc = {sst[CHAN_W:1], nxt.sat_acc[SAT_Q_W-2:0], sst[0]};
				end
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_div[k] <= 1'b0;
			end else if (ready_div[k]) begin
				valid_div[k] <= valid_div[k-1];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (ready_div[k] && valid_div[k-1]) begin
				div_s[k] <= nxt;
			end
		end

		// backpressure from the next stage
		if (k < HUE_DIV_STAGES) begin : g_mid
			assign ready_div[k-1] = !valid_div[k-1] || ready_div[k];
		end else begin : g_last
			assign ready_div[k-1] = !valid_div[k-1] || ready_div[k];
			assign ready_div[k]   = !valid_div[k] || ready_s9;
		end
	end

	// ------------------------------------------------------------------
	// stage 9: sign, sector offset, wrap, grey override; output register
	// ------------------------------------------------------------------
	logic [HUE_Q_W-1:0]   hue_q;
	logic [HUE_SUM_W-1:0] base_x, q_x, hue_sum, hue_wrap;
	logic [HUE_W-1:0]     hue_c;
	logic [CHAN_W-1:0]    sat_c;

	logic              valid_s9;
	logic [HUE_W-1:0]  hue_s9;
	logic [CHAN_W-1:0] sat_s9, val_s9;

	// sector offset
	always_comb begin
		case (div_s[HUE_DIV_STAGES].sector)
			SECT_RED:   base_x = '0;
			SECT_GREEN: base_x = HUE_SUM_W'(HUE_OFS_GREEN);
			SECT_BLUE:  base_x = HUE_SUM_W'(HUE_OFS_BLUE);
			default:    base_x = '0;
		endcase
	end

	// signed hue and wrap into one turn
	always_comb begin
		hue_q    = div_s[HUE_DIV_STAGES].hue_acc[HUE_Q_W-1:0];
		q_x      = {{(HUE_SUM_W-HUE_Q_W){1'b0}}, hue_q};
		hue_sum  = div_s[HUE_DIV_STAGES].neg ? (base_x - q_x) : (base_x + q_x);
		hue_wrap = hue_sum[HUE_SUM_W-1] ? (hue_sum + HUE_SUM_W'(HUE_FULL)) : hue_sum;
		if (div_s[HUE_DIV_STAGES].grey) begin
			hue_c = '0;
			sat_c = '0;
		end else begin
			hue_c = hue_wrap[HUE_W-1:0];
			sat_c = div_s[HUE_DIV_STAGES].sat_acc[SAT_Q_W-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (ready_s9) begin
			valid_s9 <= valid_div[HUE_DIV_STAGES];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ready_s9 && valid_div[HUE_DIV_STAGES]) begin
			hue_s9 <= hue_c;
			sat_s9 <= sat_c;
			val_s9 <= div_s[HUE_DIV_STAGES].hi;
		end
	end

	assign ready_s9    = !valid_s9 || hsv.ready;
	assign rgb.ready   = ready_s1;
	assign hsv.valid   = valid_s9;
	assign hsv.hue_out = hue_s9;
	assign hsv.sat_out = sat_s9;
	assign hsv.val_out = val_s9;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`RGBHSV_ASSERT(a_empty_out_ready, clk, arst_n, !hsv.valid, rgb.ready,
		"input not ready although the output register is empty")
	`RGBHSV_ASSERT(a_hue_range, clk, arst_n, hsv.valid, hsv.hue_out < HUE_W'(HUE_FULL),
		"hue beyond one full turn")
	`RGBHSV_ASSERT(a_grey_hue, clk, arst_n, hsv.valid && hsv.sat_out == '0,
		hsv.hue_out == '0, "zero saturation with nonzero hue")
	`RGBHSV_ASSERT_NEXT(a_accept_s1, clk, arst_n, rgb.valid && rgb.ready, valid_s1,
		"accepted beat missing from stage 1")

endmodule

[test/rgb_to_hsv_pixel_checker.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_checker
// Watches both pixel channels of the converter. Every accepted rgb beat is
// turned into the hsv pixel it must produce, and every accepted hsv beat is
// compared field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_checker
	import rgbhsv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	rgbhsv_rgb_if rgb,
	rgbhsv_hsv_if hsv,
	output int    mismatches,
	output int    in_flight,
	output int    checked
);

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] sat;
		logic [CHAN_W-1:0] val;
	} hsv_pixel_t;

	hsv_pixel_t expected_hsv[$];
	int         mismatch_cnt;
	int         checked_cnt;

	// fixed-point hsv of one pixel, hue in 1/64 degree
	function automatic hsv_pixel_t rgb_to_hsv(input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		int         red;
		int         grn;
		int         blu;
		int         top;
		int         bot;
		int         span;
		int         diff;
		int         hue;
		int         sat;
		sector_t    sector;
		hsv_pixel_t res;
		red = r;
		grn = g;
		blu = b;
		top = red;
		if (grn > top) top = grn;
		if (blu > top) top = blu;
		bot = red;
		if (grn < bot) bot = grn;
		if (blu < bot) bot = blu;
		span = top - bot;
		hue  = 0;
		sat  = 0;
		// grey pixels, black among them, keep hue and saturation at zero
		if (span != 0) begin
			sat = (span * CHAN_MAX) / top;
			// ties go to red, then green
			if (red == top)
				sector = SECT_RED;
			else if (grn == top)
				sector = SECT_GREEN;
			else
				sector = SECT_BLUE;
			case (sector)
				SECT_RED: begin
					diff = grn - blu;
					hue  = (HUE_SIXTH * diff) / span;
				end
				SECT_GREEN: begin
					diff = blu - red;
					hue  = (HUE_SIXTH * diff) / span + HUE_OFS_GREEN;
				end
				default: begin
					diff = red - grn;
					hue  = (HUE_SIXTH * diff) / span + HUE_OFS_BLUE;
				end
			endcase
			// int division truncates toward zero; wrap negatives onto the circle
			if (hue < 0) hue += HUE_FULL;
		end
		res.hue = hue[HUE_W-1:0];
		res.sat = sat[CHAN_W-1:0];
		res.val = top[CHAN_W-1:0];
		return res;
	endfunction

	// scoreboard: compare result beats, then record new pixel beats
	always @(posedge clk or negedge arst_n) begin : track
		hsv_pixel_t want;
		if (!arst_n) begin
			expected_hsv.delete();
			mismatch_cnt = 0;
			checked_cnt  = 0;
		end else begin
			if (hsv.valid && hsv.ready) begin
				if (expected_hsv.size() == 0) begin
					$error("hsv beat with nothing outstanding: hue %0d sat %0d val %0d",
						hsv.hue_out, hsv.sat_out, hsv.val_out);
					mismatch_cnt++;
				end else begin
					want = expected_hsv.pop_front();
					checked_cnt++;
					if (hsv.hue_out !== want.hue) begin
						$error("hue_out: expected %0d, got %0d", want.hue, hsv.hue_out);
						mismatch_cnt++;
					end
					if (hsv.sat_out !== want.sat) begin
						$error("sat_out: expected %0d, got %0d", want.sat, hsv.sat_out);
						mismatch_cnt++;
					end
					if (hsv.val_out !== want.val) begin
						$error("val_out: expected %0d, got %0d", want.val, hsv.val_out);
						mismatch_cnt++;
					end
				end
			end
			if (rgb.valid && rgb.ready)
				expected_hsv.push_back(rgb_to_hsv(rgb.red_in, rgb.green_in, rgb.blue_in));
		end
		mismatches <= mismatch_cnt;
		in_flight  <= expected_hsv.size();
		checked    <= checked_cnt;
	end

endmodule

[test/rgb_to_hsv_pixel_tb.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb
// Drives the converter with a directed set of corner pixels and then random
// pixels biased toward ties and near-grey values, with bursty input and a
// stalling output; the checker beside the block judges every hsv beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb;
	import rgbhsv_pkg::*;

	localparam int RANDOM_PIXELS = 780;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 24;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PATTERN,
		READY_SCARCE
	} stall_mode_t;

	typedef enum logic [1:0] {
		PIX_UNIFORM,
		PIX_TIED,
		PIX_GREYISH,
		PIX_EXTREME
	} pixel_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   in_flight;
	int   checked;
	int   sent;
	int   directed;
	int   burst_left;
	int   idle_cycles = 0;
	int   stall_cycles = 0;

	rgbhsv_rgb_if rgb ();
	rgbhsv_hsv_if hsv ();

	always #2 clk = ~clk;

	rgb_to_hsv_pixel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb),
		.hsv    (hsv)
	);

	rgb_to_hsv_pixel_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rgb        (rgb),
		.hsv        (hsv),
		.mismatches (fail_count),
		.in_flight  (in_flight),
		.checked    (checked)
	);

	// one pixel beat, then a random gap once the current burst runs out
	task automatic push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b);
		int gap;
		rgb.valid    <= 1'b1;
		rgb.red_in   <= r;
		rgb.green_in <= g;
		rgb.blue_in  <= b;
		@(posedge clk);
		while (!rgb.ready) @(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
			// junk on the data lines while valid is low
			rgb.valid    <= 1'b0;
			rgb.red_in   <= CHAN_W'($urandom);
			rgb.green_in <= CHAN_W'($urandom);
			rgb.blue_in  <= CHAN_W'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 8);
		end
	endtask

	// random pixel, leaning toward tied channel pairs, near-grey and the range ends
	task automatic random_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
		output logic [CHAN_W-1:0] b);
		pixel_kind_t kind;
		int          pick;
		int          base;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			kind = PIX_UNIFORM;
		else if (pick < 8)
			kind = PIX_TIED;
		else if (pick == 8)
			kind = PIX_GREYISH;
		else
			kind = PIX_EXTREME;
		r = CHAN_W'($urandom);
		g = CHAN_W'($urandom);
		b = CHAN_W'($urandom);
		case (kind)
			PIX_TIED: begin
				case ($urandom_range(0, 2))
					0: g = r;
					1: b = g;
					default: b = r;
				endcase
			end
			PIX_GREYISH: begin
				base = $urandom_range(0, 253);
				r = CHAN_W'(base + $urandom_range(0, 2));
				g = CHAN_W'(base + $urandom_range(0, 2));
				b = CHAN_W'(base + $urandom_range(0, 2));
			end
			PIX_EXTREME: begin
				if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'd254 : 8'd1;
				if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: ;
		endcase
	endtask

	// result side: drives hsv.ready from a randomly redrawn stall mode
	initial begin : receiver
		stall_mode_t mode;
		int          cyc;
		hsv.ready = 1'b0;
		mode      = READY_ALWAYS;
		cyc       = 0;
		forever begin
			@(posedge clk);
			if (cyc % 48 == 0) mode = stall_mode_t'($urandom_range(0, 3));
			case (mode)
				READY_ALWAYS:  hsv.ready <= 1'b1;
				READY_RANDOM:  hsv.ready <= ($urandom_range(0, 3) != 0);
				READY_PATTERN: hsv.ready <= (cyc % 5 < 3);
				default:       hsv.ready <= ($urandom_range(0, 3) == 0);
			endcase
			cyc++;
		end
	end

	// watchdog on cycles without any beat, plus stall statistics
	always @(posedge clk) begin
		if (hsv.valid && !hsv.ready) stall_cycles <= stall_cycles + 1;
		if (!arst_n || (rgb.valid && rgb.ready) || (hsv.valid && hsv.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, in_flight);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// pixel side and verdict
	initial begin : sender
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		arst_n       = 1'b0;
		rgb.valid    = 1'b0;
		rgb.red_in   = '0;
		rgb.green_in = '0;
		rgb.blue_in  = '0;
		sent         = 0;
		burst_left   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// grey, black and white
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd128, 8'd128, 8'd128);
		// primaries
		push_pixel(8'd255, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd255, 8'd0);
		push_pixel(8'd0, 8'd0, 8'd255);
		// tied maxima: red wins over green and blue, green over blue
		push_pixel(8'd255, 8'd255, 8'd0);
		push_pixel(8'd0, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd0, 8'd255);
		// negative hue wraps, truncation toward zero
		push_pixel(8'd255, 8'd0, 8'd1);
		push_pixel(8'd200, 8'd10, 8'd20);
		// saturation extremes
		push_pixel(8'd1, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd254, 8'd254);
		// negative diff in the green and blue sectors
		push_pixel(8'd10, 8'd200, 8'd0);
		push_pixel(8'd0, 8'd10, 8'd200);
		// small values and alternating bit patterns
		push_pixel(8'd1, 8'd2, 8'd3);
		push_pixel(8'd170, 8'd85, 8'd0);
		push_pixel(8'd85, 8'd170, 8'd255);
		push_pixel(8'd254, 8'd1, 8'd127);
		push_pixel(8'd127, 8'd128, 8'd129);
		directed = sent;

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			random_pixel(r, g, b);
			push_pixel(r, g, b);
		end
		rgb.valid <= 1'b0;

		// drain everything still in the pipe
		do @(posedge clk); while (in_flight != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d pixel beats (%0d directed corners, rest random)",
			sent, directed);
		$display("%0d hsv beats checked, %0d cycles with the result side stalled",
			checked, stall_cycles);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/rgbhsv_pkg.sv
sv/rgbhsv_if.sv
sv/rgb_to_hsv_pixel.sv
test/rgb_to_hsv_pixel_checker.sv
test/rgb_to_hsv_pixel_tb.sv
